>>> sv/clis_pkg.sv
package clis_pkg;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] value;
        logic       row;
        logic [5:0] col;
    } req_t;

    typedef struct packed {
        logic [7:0] expander_byte;
        logic [7:0] wait_before;
        logic [3:0] wait_after;
        logic       last;
    } wr_t;

    // classified request handed from the front to the sequencer
    typedef struct packed {
        logic       is_init;
        logic [7:0] byte_val;
        logic       rs;
        logic [3:0] extra;
    } desc_t;

    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_BYTE   = 2'd1;
    localparam logic [1:0] CMD_DATA   = 2'd2;
    localparam logic [1:0] CMD_CURSOR = 2'd3;

    localparam logic [7:0] LCD_CLEAR      = 8'h01;
    localparam logic [7:0] LCD_HOME       = 8'h02;
    localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;
    localparam logic [7:0] LCD_ROW1_BASE  = 8'h40;
    localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
    localparam logic [7:0] LCD_DISP_ON    = 8'h0C;
    localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;

    localparam logic [3:0] NIB_WAKE = 4'h3;
    localparam logic [3:0] NIB_4BIT = 4'h2;

    localparam logic [3:0] EXTRA_SHORT     = 4'd1;
    localparam logic [3:0] EXTRA_LONG      = 4'd2;
    localparam logic [3:0] EXTRA_WAKE_SLOW = 4'd10;
    localparam logic [3:0] EXTRA_LAST_INIT = 4'd7;
    localparam logic [3:0] HOLD_BASE       = 4'd1;

    localparam logic [7:0] INIT_PRE_WAIT   = 8'd200;
    localparam logic [4:0] INIT_NIB_WRITES = 5'd8;
    localparam logic [4:0] INIT_LAST_STEP  = 5'd23;

    function automatic logic [7:0] init_cmd(input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = LCD_FUNC_SET;
            2'd1:    b = LCD_DISP_ON;
            2'd2:    b = LCD_ENTRY_MODE;
            default: b = LCD_CLEAR;
        endcase
        return b;
    endfunction

endpackage

>>> sv/clis_front.sv
module clis_front (
    input  logic            req_valid,
    output logic            req_stall,
    input  clis_pkg::req_t  req,
    input  logic            queue_full,
    output logic            push,
    output clis_pkg::desc_t desc
);
    import clis_pkg::*;

    logic [7:0] cursor_byte;

    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full;

    assign cursor_byte = LCD_SET_DDRAM | ((req.row ? LCD_ROW1_BASE : 8'h00) + {2'b00, req.col});

    always_comb
    begin
        desc = '0;
        unique case (req.cmd)
            CMD_INIT:
            begin
                desc.is_init  = 1'b1;
                desc.byte_val = '0;
                desc.rs       = 1'b0;
                desc.extra    = '0;
            end
            CMD_BYTE:
            begin
                desc.byte_val = req.value;
                desc.rs       = 1'b0;
                // clear and home need the longer hold
                desc.extra    = (req.value == LCD_CLEAR || req.value == LCD_HOME)
                                ? EXTRA_LONG : EXTRA_SHORT;
            end
            CMD_DATA:
            begin
                desc.byte_val = req.value;
                desc.rs       = 1'b1;
                desc.extra    = EXTRA_SHORT;
            end
            default:
            begin
                desc.byte_val = cursor_byte;
                desc.rs       = 1'b0;
                desc.extra    = EXTRA_SHORT;
            end
        endcase
    end

endmodule

>>> sv/clis_queue.sv
module clis_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  clis_pkg::desc_t push_data,
    input  logic            pop,
    output clis_pkg::desc_t pop_data,
    output logic            full,
    output logic            empty
);
    import clis_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/clis_back.sv
module clis_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            queue_empty,
    input  clis_pkg::desc_t queue_data,
    output logic            pop,
    output logic            wr_valid,
    input  logic            wr_stall,
    output clis_pkg::wr_t   wr
);
    import clis_pkg::*;

    logic       busy_reg, busy_next;
    desc_t      cur_reg, cur_next;
    logic [4:0] step_reg, step_next;
    logic       wr_valid_reg, wr_valid_next;
    wr_t        wr_reg, wr_next;

    logic       advance;
    logic [4:0] init_idx;
    logic [1:0] w;
    logic [7:0] b;
    logic [3:0] extra;
    logic [3:0] nib;
    logic       en;
    logic [3:0] hold;
    logic [7:0] pre_wait;
    logic       is_last;

    assign advance = busy_reg && (!wr_valid_reg || !wr_stall);

    // decode the current write from the step number
    always_comb
    begin
        init_idx = step_reg - INIT_NIB_WRITES;
        w        = step_reg[1:0];
        b        = cur_reg.byte_val;
        extra    = cur_reg.extra;
        nib      = '0;
        hold     = HOLD_BASE;
        pre_wait = '0;
        is_last  = 1'b0;
        en       = !step_reg[0];
        if (cur_reg.is_init && step_reg < INIT_NIB_WRITES)
        begin
            // wake-up nibbles 3,3,3 then 2
            nib      = (step_reg[2:1] == 2'd3) ? NIB_4BIT : NIB_WAKE;
            extra    = (step_reg[2:1] < 2'd2) ? EXTRA_WAKE_SLOW : EXTRA_LONG;
            hold     = step_reg[0] ? HOLD_BASE + extra : HOLD_BASE;
            pre_wait = (step_reg == '0) ? INIT_PRE_WAIT : 8'd0;
        end
        else
        begin
            if (cur_reg.is_init)
            begin
                w       = init_idx[1:0];
                b       = init_cmd(init_idx[3:2]);
                extra   = (init_idx[3:2] == 2'd3) ? EXTRA_LAST_INIT : EXTRA_SHORT;
                is_last = (step_reg == INIT_LAST_STEP);
            end
            else
            begin
                is_last = (w == 2'd3);
            end
            nib  = w[1] ? b[3:0] : b[7:4];
            hold = (w == 2'd3) ? HOLD_BASE + extra : HOLD_BASE;
        end
    end

    assign pop = !queue_empty && (!busy_reg || (advance && is_last));

    always_comb
    begin
        busy_next     = busy_reg;
        cur_next      = cur_reg;
        step_next     = step_reg;
        wr_valid_next = wr_valid_reg;
        wr_next       = wr_reg;
        if (advance)
        begin
            wr_valid_next             = 1'b1;
            wr_next.expander_byte     = {nib, 1'b1, en, 1'b0, cur_reg.rs};
            wr_next.wait_before       = pre_wait;
            wr_next.wait_after        = hold;
            wr_next.last              = is_last;
            step_next                 = step_reg + 1'b1;
            if (is_last)
            begin
                busy_next = 1'b0;
            end
        end
        else if (!wr_stall)
        begin
            wr_valid_next = 1'b0;
        end
        if (pop)
        begin
            busy_next = 1'b1;
            cur_next  = queue_data;
            step_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            step_reg     <= step_next;
            wr_valid_reg <= wr_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        wr_reg  <= wr_next;
    end

    assign wr_valid = wr_valid_reg;
    assign wr       = wr_reg;

endmodule

>>> sv/char_lcd_i2c_expander_sequencer_unit.sv
// a request reaches the output via the queue, the current-request reg and the write reg
// one write per cycle while wr_stall is low; a byte request makes 4 writes, init makes 24
// requests queue ahead of the sequencer, so the next one starts right after the last write
// the write sequencer and the request queue set the rate
// reset clears the queue, the sequencer and the output valid; payload regs are not reset
module char_lcd_i2c_expander_sequencer_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  clis_pkg::req_t req,
    output logic           wr_valid,
    input  logic           wr_stall,
    output clis_pkg::wr_t  wr
);
    import clis_pkg::*;

    logic  push;
    desc_t push_desc;
    logic  pop;
    desc_t pop_desc;
    logic  queue_full;
    logic  queue_empty;

    clis_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (queue_full),
        .push       (push),
        .desc       (push_desc)
    );

    clis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .pop       (pop),
        .pop_data  (pop_desc),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    clis_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .queue_data  (pop_desc),
        .pop         (pop),
        .wr_valid    (wr_valid),
        .wr_stall    (wr_stall),
        .wr          (wr)
    );

endmodule
